>>> src/tfa_pkg.sv
package tfa_pkg;

   localparam int COORD_W     = 12;
   localparam int DIM_W       = 13;
   localparam int EDGE_W      = 9;
   localparam int REM_W       = EDGE_W - 1;
   localparam int INDEX_W     = 24;
   localparam int PROD_W      = COORD_W + DIM_W;
   localparam int REQ_DATA_W  = 2 * COORD_W;
   localparam int RSP_DATA_W  = INDEX_W;

   localparam int MAX_WIDTH   = 4096;
   localparam int MAX_HEIGHT  = 4096;
   localparam int MAX_TILE    = 256;

   localparam int RESET_WIDTH  = 1920;
   localparam int RESET_HEIGHT = 1080;
   localparam int RESET_EDGE   = 32;

   // Dividend bits brought down per divider stage.
   localparam int DIV_STEPS   = 3;
   localparam int DIV_STAGES  = COORD_W / DIV_STEPS;
   // Divider stages, tile clip stage, multiply stage, sum stage.
   localparam int PIPE_STAGES = DIV_STAGES + 3;

   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = DIM_W;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FRAME_WIDTH  = 2'd0,
      CSR_FRAME_HEIGHT = 2'd1,
      CSR_TILE_EDGE    = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [REM_W-1:0]   rem;
      logic [COORD_W-1:0] dvd;
      logic [COORD_W-1:0] org;
   } div_lane_type;

   typedef struct packed {
      logic         oor;
      div_lane_type x;
      div_lane_type y;
   } div_item_type;

   typedef struct packed {
      logic               oor;
      logic [COORD_W-1:0] x0;
      logic [COORD_W-1:0] y0;
      logic [REM_W-1:0]   sx;
      logic [REM_W-1:0]   sy;
      logic [EDGE_W-1:0]  tw;
      logic [EDGE_W-1:0]  th;
   } tile_item_type;

   // One restoring step: bring down the next dividend bit and subtract the
   // tile edge when it fits. The remainder always stays below the edge.
   function automatic div_lane_type div_step(div_lane_type lane,
                                             logic [EDGE_W-1:0] edge_len);
      logic [EDGE_W-1:0] trial;
      div_lane_type      nxt;
      nxt   = lane;
      trial = {lane.rem, lane.dvd[COORD_W-1]};
      nxt.dvd = {lane.dvd[COORD_W-2:0], 1'b0};
      if (trial >= edge_len) begin
         trial = trial - edge_len;
      end
      nxt.rem = trial[REM_W-1:0];
      return nxt;
   endfunction

endpackage

>>> src/tfa_div_stage.sv
module tfa_div_stage
   import tfa_pkg::*;
(
   input  logic              clock,
   input  logic              en,
   input  logic [EDGE_W-1:0] edge_len,
   input  div_item_type      item_i,
   output div_item_type      item_o
);

   div_item_type item_in;
   div_item_type item_ff;

   always_comb begin
      item_in = item_i;
      for (int i = 0; i < DIV_STEPS; i++) begin
         item_in.x = div_step(item_in.x, edge_len);
         item_in.y = div_step(item_in.y, edge_len);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         item_ff <= item_in;
      end
   end

   assign item_o = item_ff;

endmodule

>>> src/tfa_tile.sv
module tfa_tile
   import tfa_pkg::*;
(
   input  logic              clock,
   input  logic              en,
   input  logic [DIM_W-1:0]  width,
   input  logic [DIM_W-1:0]  height,
   input  logic [EDGE_W-1:0] edge_len,
   input  div_item_type      item_i,
   output tile_item_type     item_o
);

   logic [COORD_W-1:0] x0, y0;
   logic [DIM_W-1:0]   xe, ye, xe_clip, ye_clip, tw_full, th_full;
   tile_item_type      item_in;
   tile_item_type      item_ff;

   always_comb begin
      x0 = item_i.x.org - {{(COORD_W-REM_W){1'b0}}, item_i.x.rem};
      y0 = item_i.y.org - {{(COORD_W-REM_W){1'b0}}, item_i.y.rem};
      xe = {1'b0, x0} + {{(DIM_W-EDGE_W){1'b0}}, edge_len};
      ye = {1'b0, y0} + {{(DIM_W-EDGE_W){1'b0}}, edge_len};
      // Edge tiles are clipped to the frame.
      xe_clip = (xe > width)  ? width  : xe;
      ye_clip = (ye > height) ? height : ye;
      tw_full = xe_clip - {1'b0, x0};
      th_full = ye_clip - {1'b0, y0};

      item_in.oor = item_i.oor;
      item_in.x0  = x0;
      item_in.y0  = y0;
      item_in.sx  = item_i.x.rem;
      item_in.sy  = item_i.y.rem;
      item_in.tw  = tw_full[EDGE_W-1:0];
      item_in.th  = th_full[EDGE_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         item_ff <= item_in;
      end
   end

   assign item_o = item_ff;

endmodule

>>> src/tfa_mac.sv
module tfa_mac
   import tfa_pkg::*;
(
   input  logic               clock,
   input  logic               en_mul,
   input  logic               en_sum,
   input  logic [DIM_W-1:0]   width,
   input  tile_item_type      item_i,
   output logic [INDEX_W-1:0] linear_index,
   output logic               out_of_range
);

   localparam int XT_W = COORD_W + EDGE_W;
   localparam int ST_W = REM_W + EDGE_W;

   logic [PROD_W-1:0]  yw_in, yw_ff;
   logic [XT_W-1:0]    xt_in, xt_ff;
   logic [ST_W-1:0]    st_in, st_ff;
   logic [REM_W-1:0]   sx_ff;
   logic               oor_mul_ff;
   logic [PROD_W-1:0]  sum;
   logic [INDEX_W-1:0] index_in, index_ff;
   logic               oor_ff;

   always_comb begin
      yw_in = {{DIM_W{1'b0}}, item_i.y0} * {{COORD_W{1'b0}}, width};
      xt_in = {{EDGE_W{1'b0}}, item_i.x0} * {{COORD_W{1'b0}}, item_i.th};
      st_in = {{EDGE_W{1'b0}}, item_i.sy} * {{REM_W{1'b0}}, item_i.tw};
   end

   always_ff @(posedge clock) begin
      if (en_mul) begin
         yw_ff      <= yw_in;
         xt_ff      <= xt_in;
         st_ff      <= st_in;
         sx_ff      <= item_i.sx;
         oor_mul_ff <= item_i.oor;
      end
   end

   always_comb begin
      sum = yw_ff + PROD_W'(xt_ff) + PROD_W'(st_ff) + PROD_W'(sx_ff);
      index_in = oor_mul_ff ? '0 : sum[INDEX_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (en_sum) begin
         index_ff <= index_in;
         oor_ff   <= oor_mul_ff;
      end
   end

   assign linear_index = index_ff;
   assign out_of_range = oor_ff;

endmodule

>>> src/tiled_framebuffer_address.sv
// Tiled frame buffer address generator. Each request word carries a pixel
// coordinate; the response word gives its offset in a buffer stored tile by
// tile (tiles row by row, pixels row-major inside a tile, right and bottom
// edge tiles clipped and packed), with out_of_range set and a zero offset for
// coordinates outside the frame. One word is taken per cycle unless the
// pipeline is full and the response side holds off. There are seven register
// stages: four stages of a pipelined restoring divider (three dividend bits
// each) split the coordinate by the tile edge, followed by a tile clip stage,
// a multiply stage and a sum stage that is also the output register and holds
// a response word while the response side holds off. The user must write
// frame size and tile edge on the csr port only while no request is in
// flight; the block does not enforce this. Widths and heights above 4096 and
// tile edges whose low nine bits exceed 256 saturate; a zero edge acts as one.
module tiled_framebuffer_address
   import tfa_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // pos_x [11:0], pos_y [23:12]
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // linear_index [23:0]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // out_of_range [0]
   output logic                  rsp_tuser,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   logic [DIM_W-1:0]       frame_width_ff, frame_height_ff;
   logic [EDGE_W-1:0]      tile_edge_ff;
   logic [DIM_W-1:0]       width_eff, height_eff;
   logic [EDGE_W-1:0]      edge_eff;
   logic [PIPE_STAGES-1:0] valid_ff, valid_in, stage_rdy;
   logic [COORD_W-1:0]     pos_x, pos_y;
   div_item_type           in_item;
   div_item_type           div_in  [DIV_STAGES];
   div_item_type           div_out [DIV_STAGES];
   tile_item_type          tile_item;
   logic [INDEX_W-1:0]     linear_index;
   logic                   out_of_range;

   // Configuration registers.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= DIM_W'(RESET_WIDTH);
         frame_height_ff <= DIM_W'(RESET_HEIGHT);
         tile_edge_ff    <= EDGE_W'(RESET_EDGE);
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_FRAME_WIDTH:  frame_width_ff  <= csr_data;
            CSR_FRAME_HEIGHT: frame_height_ff <= csr_data;
            CSR_TILE_EDGE:    tile_edge_ff    <= csr_data[EDGE_W-1:0];
            default:          ;
         endcase
      end
   end

   always_comb begin
      width_eff  = (frame_width_ff > DIM_W'(MAX_WIDTH)) ?
                   DIM_W'(MAX_WIDTH) : frame_width_ff;
      height_eff = (frame_height_ff > DIM_W'(MAX_HEIGHT)) ?
                   DIM_W'(MAX_HEIGHT) : frame_height_ff;
      priority if (tile_edge_ff == '0) begin
         edge_eff = EDGE_W'(1);
      end else if (tile_edge_ff > EDGE_W'(MAX_TILE)) begin
         edge_eff = EDGE_W'(MAX_TILE);
      end else begin
         edge_eff = tile_edge_ff;
      end
   end

   // Pipeline flow control: a stage takes a new word when it is empty or
   // when the stage after it moves on.
   always_comb begin
      stage_rdy[PIPE_STAGES-1] = !valid_ff[PIPE_STAGES-1] || rsp_tready;
      for (int i = PIPE_STAGES - 2; i >= 0; i--) begin
         stage_rdy[i] = !valid_ff[i] || stage_rdy[i+1];
      end
      valid_in[0] = stage_rdy[0] ? req_tvalid : valid_ff[0];
      for (int i = 1; i < PIPE_STAGES; i++) begin
         valid_in[i] = stage_rdy[i] ? valid_ff[i-1] : valid_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_tready = stage_rdy[0];
   assign rsp_tvalid = valid_ff[PIPE_STAGES-1];
   assign rsp_tdata  = linear_index;
   assign rsp_tuser  = out_of_range;

   // Range check happens on entry; the flag rides with the word.
   always_comb begin
      pos_x = req_tdata[COORD_W-1:0];
      pos_y = req_tdata[2*COORD_W-1:COORD_W];
      in_item.oor   = ({1'b0, pos_x} >= width_eff) || ({1'b0, pos_y} >= height_eff);
      in_item.x.rem = '0;
      in_item.x.dvd = pos_x;
      in_item.x.org = pos_x;
      in_item.y.rem = '0;
      in_item.y.dvd = pos_y;
      in_item.y.org = pos_y;
   end

   for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
      if (k == 0) begin : g_first
         assign div_in[k] = in_item;
      end else begin : g_next
         assign div_in[k] = div_out[k-1];
      end
      tfa_div_stage u_div_stage (
         .clock    (clock),
         .en       (stage_rdy[k]),
         .edge_len (edge_eff),
         .item_i   (div_in[k]),
         .item_o   (div_out[k])
      );
   end

   tfa_tile u_tile (
      .clock    (clock),
      .en       (stage_rdy[DIV_STAGES]),
      .width    (width_eff),
      .height   (height_eff),
      .edge_len (edge_eff),
      .item_i   (div_out[DIV_STAGES-1]),
      .item_o   (tile_item)
   );

   tfa_mac u_mac (
      .clock        (clock),
      .en_mul       (stage_rdy[DIV_STAGES+1]),
      .en_sum       (stage_rdy[DIV_STAGES+2]),
      .width        (width_eff),
      .item_i       (tile_item),
      .linear_index (linear_index),
      .out_of_range (out_of_range)
   );

endmodule

>>> src/tfa_checker.sv
module tfa_checker
   import tfa_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic                  rsp_tuser
);

   // An out-of-range word always reports offset zero.
   a_oor_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == '0)
      else $error("out-of-range response with nonzero offset");

   // A response that is taken frees the whole pipeline for a new request.
   a_flow : assert property (@(posedge clock) disable iff (reset)
      rsp_tready |-> req_tready)
      else $error("request stalled while response side is ready");

   // Reset empties the pipeline.
   a_reset : assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   // A stalled response word holds.
   a_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled response word changed");

endmodule

bind tiled_framebuffer_address tfa_checker u_tfa_checker (.*);

>>> verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
   import tfa_pkg::*;

   // Index past the end of the register map; writes to it must be dropped.
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED = 2'd3;

   typedef struct packed {
      logic [COORD_W-1:0] y;
      logic [COORD_W-1:0] x;
   } pixel_coord_type;

   typedef struct packed {
      logic [INDEX_W-1:0] index;
      logic               oor;
   } pixel_result_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_FRAME_WIDTH;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   // Local copy of the register file, as the block should see it.
   logic [DIM_W-1:0]      width_reg  = DIM_W'(RESET_WIDTH);
   logic [DIM_W-1:0]      height_reg = DIM_W'(RESET_HEIGHT);
   logic [EDGE_W-1:0]     edge_reg   = EDGE_W'(RESET_EDGE);

   pixel_coord_type       pending_coords[$];
   pixel_result_type      expected_offsets[$];
   int                    idle_pct = 18;
   int                    mismatch_count = 0;

   tiled_framebuffer_address dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #6 clock = ~clock;

   function automatic int unsigned eff_dim(input logic [DIM_W-1:0] r, input int unsigned limit);
      return (r > limit) ? limit : r;
   endfunction

   function automatic int unsigned eff_edge(input logic [EDGE_W-1:0] r);
      if (r == 0) begin
         return 1;
      end
      return (r > MAX_TILE) ? MAX_TILE : r;
   endfunction

   function automatic pixel_result_type tile_offset(input logic [COORD_W-1:0] px,
                                                    input logic [COORD_W-1:0] py);
      int unsigned      w, h, e, x0, y0, tw, th;
      pixel_result_type r;
      w = eff_dim(width_reg, MAX_WIDTH);
      h = eff_dim(height_reg, MAX_HEIGHT);
      e = eff_edge(edge_reg);
      r.oor   = (px >= w) || (py >= h);
      r.index = '0;
      if (!r.oor) begin
         x0 = (px / e) * e;
         y0 = (py / e) * e;
         // Tiles on the right and bottom edges are clipped to the frame.
         tw = (x0 + e > w) ? w - x0 : e;
         th = (y0 + e > h) ? h - y0 : e;
         r.index = INDEX_W'(y0 * w + x0 * th + (px - x0) + (py - y0) * tw);
      end
      return r;
   endfunction

   // Mostly in-frame coordinates, with some on frame and tile borders and
   // some anywhere in the coordinate range.
   function automatic logic [COORD_W-1:0] pick_coord(input int unsigned limit,
                                                     input int unsigned e);
      int unsigned v;
      case ($urandom_range(9))
         0: v = $urandom_range(4095);
         1: v = (limit == 0) ? 0 : limit - 1 + $urandom_range(1);
         2: begin
            v = e * $urandom_range(4095 / e);
            if (v > 0 && $urandom_range(1) == 1) begin
               v = v - 1;
            end
         end
         default: v = (limit == 0) ? $urandom_range(4095) : $urandom_range(limit - 1);
      endcase
      if (v > 4095) begin
         v = 4095;
      end
      return COORD_W'(v);
   endfunction

   function automatic logic [DIM_W-1:0] random_dim();
      case ($urandom_range(9))
         0: return DIM_W'($urandom_range(1, 16));
         1: return DIM_W'($urandom_range(4097, 8191));
         default: return DIM_W'($urandom_range(1, 4096));
      endcase
   endfunction

   function automatic logic [CSR_DATA_W-1:0] random_edge();
      case ($urandom_range(9))
         0: return '0;
         1: return CSR_DATA_W'($urandom_range(257, 8191));
         2: return CSR_DATA_W'($urandom_range(1, 8));
         default: return CSR_DATA_W'($urandom_range(1, 256));
      endcase
   endfunction

   // Leaves csr_valid high; the caller lowers it after its last write so that
   // back-to-back writes never assign the valid twice in one step.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) begin
         @(posedge clock);
      end
      case (idx)
         CSR_FRAME_WIDTH:  width_reg  = value;
         CSR_FRAME_HEIGHT: height_reg = value;
         CSR_TILE_EDGE:    edge_reg   = value[EDGE_W-1:0];
         default: ;
      endcase
   endtask

   task automatic set_frame(input logic [CSR_DATA_W-1:0] w,
                            input logic [CSR_DATA_W-1:0] h,
                            input logic [CSR_DATA_W-1:0] e);
      write_reg(CSR_FRAME_WIDTH, w);
      write_reg(CSR_FRAME_HEIGHT, h);
      write_reg(CSR_TILE_EDGE, e);
      csr_valid <= 1'b0;
   endtask

   task automatic add_coord(input int unsigned px, input int unsigned py);
      pending_coords.push_back('{y: COORD_W'(py), x: COORD_W'(px)});
   endtask

   task automatic queue_random_coords(input int count);
      int unsigned w, h, e;
      w = eff_dim(width_reg, MAX_WIDTH);
      h = eff_dim(height_reg, MAX_HEIGHT);
      e = eff_edge(edge_reg);
      for (int i = 0; i < count; i++) begin
         pending_coords.push_back('{y: pick_coord(h, e), x: pick_coord(w, e)});
      end
   endtask

   // Returns once every queued word has been answered and the pipeline has
   // had time to drain.
   task automatic wait_idle();
      while (pending_coords.size() != 0 || req_tvalid || expected_offsets.size() != 0) begin
         @(posedge clock);
      end
      repeat (PIPE_STAGES + 2) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_offsets.push_back(tile_offset(req_tdata[COORD_W-1:0],
                                                   req_tdata[2*COORD_W-1:COORD_W]));
         end
         if (!req_tvalid || req_tready) begin
            if (pending_coords.size() != 0 && $urandom_range(99) >= idle_pct) begin
               req_tvalid <= 1'b1;
               req_tdata  <= pending_coords.pop_front();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      pixel_result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= idle_pct);
         if (rsp_tvalid && rsp_tready) begin
            if (expected_offsets.size() == 0) begin
               $display("%0t: unexpected response word, expected none, got index %0d oor %0b",
                        $realtime, rsp_tdata, rsp_tuser);
               mismatch_count++;
            end else begin
               want = expected_offsets.pop_front();
               if (rsp_tdata !== want.index) begin
                  $display("%0t: linear_index mismatch, expected %0d, got %0d",
                           $realtime, want.index, rsp_tdata);
                  mismatch_count++;
               end
               if (rsp_tuser !== want.oor) begin
                  $display("%0t: out_of_range mismatch, expected %0b, got %0b",
                           $realtime, want.oor, rsp_tuser);
                  mismatch_count++;
               end
            end
         end
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Reset frame of 1920 x 1080 with 32-pixel tiles, bottom tile row clipped.
      add_coord(0, 0);
      add_coord(1919, 1079);
      add_coord(1920, 0);
      add_coord(0, 1080);
      add_coord(4095, 4095);
      add_coord(31, 31);
      add_coord(32, 33);
      add_coord(1900, 1070);
      add_coord(12'h555, 12'h2aa);
      add_coord(12'h2aa, 12'h155);
      wait_idle();

      // A write past the register map must leave the frame untouched.
      write_reg(CSR_UNMAPPED, 13'h0005);
      csr_valid <= 1'b0;
      add_coord(1919, 1079);
      add_coord(100, 200);
      wait_idle();

      // A zero width or height puts every coordinate out of range.
      set_frame(0, 1080, 32);
      add_coord(0, 0);
      add_coord(5, 5);
      wait_idle();
      set_frame(640, 0, 32);
      add_coord(0, 0);
      wait_idle();

      // Oversized frame saturates; a zero tile edge acts as one pixel.
      set_frame(8191, 8191, 0);
      add_coord(4095, 4095);
      add_coord(1, 4095);
      wait_idle();

      // Largest frame and tile; the upper edge bits beyond the register drop.
      set_frame(4096, 4096, 8191);
      add_coord(4095, 4095);
      add_coord(255, 256);
      add_coord(4000, 100);
      wait_idle();

      set_frame(1, 1, 1);
      add_coord(0, 0);
      add_coord(1, 0);
      add_coord(0, 1);
      wait_idle();

      // Tile edge just above the maximum, with an odd frame size.
      set_frame(4097, 17, 257);
      add_coord(4095, 16);
      add_coord(300, 10);
      wait_idle();

      for (int p = 0; p < 12; p++) begin
         // The first random frame runs without any gaps on either side.
         idle_pct = (p == 0) ? 0 : 18;
         set_frame(random_dim(), random_dim(), random_edge());
         queue_random_coords((p == 0) ? 250 : 110);
         wait_idle();
      end

      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   initial begin
      #5000000;
      $display("FAIL");
      $finish;
   end

endmodule

>>> filelist.f
src/tfa_pkg.sv
src/tfa_div_stage.sv
src/tfa_tile.sv
src/tfa_mac.sv
src/tiled_framebuffer_address.sv
src/tfa_checker.sv
verif/tb_top.sv
